>>> rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants of the positional list store
// Item and result layouts, command and status codes, controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int POS_W      = 5;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  typedef struct packed {
    cmd_t                  command;
    logic [POS_W-1:0]      position;
    logic [DATA_WIDTH-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_data;
    status_t               status;
    logic [CNT_W-1:0]      count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    load_result;
    logic    do_insert;
    logic    do_remove;
    logic    return_data;
    status_t result_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t command;
    logic pos_gt_count;
    logic pos_ge_count;
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/pls_ctrl.sv
// ----------------------------------------------------------------------------
// pls_ctrl: command sequencer of the positional list store
// Runs the handshakes and decodes each command into datapath operations.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_ctrl
  import pls_pkg::*;
(
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  wire      out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready          = 1'b0;
    out_valid         = 1'b0;
    cmd               = '0;
    cmd.result_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.load_result = 1'b1;
        case (stat.command)
          CMD_INSERT: begin
            if (stat.pos_gt_count) begin
              cmd.result_status = ST_BAD_POS;
            end else if (stat.full) begin
              cmd.result_status = ST_FULL;
            end else begin
              cmd.do_insert = 1'b1;
            end
          end
          CMD_REMOVE, CMD_PEEK: begin
            if (stat.empty) begin
              cmd.result_status = ST_EMPTY;
            end else if (stat.pos_ge_count) begin
              cmd.result_status = ST_BAD_POS;
            end else begin
              cmd.return_data = 1'b1;
              cmd.do_remove   = (stat.command == CMD_REMOVE);
            end
          end
          default: cmd.result_status = ST_OK;
        endcase
      end
      S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/pls_datapath.sv
// ----------------------------------------------------------------------------
// pls_datapath: shifting storage cells, entry count and result register
// Inserts shift the tail up and removes shift it down, all cells at once.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_datapath
  import pls_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t out_data
);

  in_item_t              item_r;
  out_item_t             res_r;
  logic [DATA_WIDTH-1:0] cell_r   [DEPTH];
  logic [DATA_WIDTH-1:0] cell_nxt [DEPTH];
  logic [DATA_WIDTH-1:0] shift_up [DEPTH];
  logic [DATA_WIDTH-1:0] shift_dn [DEPTH];
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CMP_W-1:0]      pos_ext, cnt_ext;

  assign pos_ext = CMP_W'(item_r.position);
  assign cnt_ext = CMP_W'(count_r);

  assign stat.command      = item_r.command;
  assign stat.pos_gt_count = (pos_ext > cnt_ext);
  assign stat.pos_ge_count = (pos_ext >= cnt_ext);
  assign stat.full         = (count_r == CNT_W'(DEPTH));
  assign stat.empty        = (count_r == '0);

  always_comb begin
    shift_up[0]       = cell_r[0];
    shift_dn[DEPTH-1] = cell_r[DEPTH-1];
    for (int i = 1; i < DEPTH; i++) begin
      shift_up[i] = cell_r[i-1];
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      shift_dn[i] = cell_r[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_nxt[i] = cell_r[i];
      if (cmd.do_insert) begin
        if (CMP_W'(i) == pos_ext) begin
          cell_nxt[i] = item_r.data_in;
        end else if (CMP_W'(i) > pos_ext) begin
          cell_nxt[i] = shift_up[i];
        end
      end else if (cmd.do_remove && (CMP_W'(i) >= pos_ext)) begin
        cell_nxt[i] = shift_dn[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.load_result) begin
      res_r.read_data <= cmd.return_data ? cell_r[item_r.position[IDX_W-1:0]] : '0;
      res_r.status    <= cmd.result_status;
      res_r.count     <= count_nxt;
    end
  end

  assign out_data = res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.do_insert && cmd.do_remove))
    else $error("insert and remove in one cycle");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_insert |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_count_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.load_result |=> $stable(count_r))
    else $error("count changed outside an executed command");

endmodule

`default_nettype wire

>>> rtl/positional_list_store_unit.sv
// ----------------------------------------------------------------------------
// positional_list_store_unit: ordered list of words with positional commands
// Insert, remove or peek a word at a list position; every command answers
// with a status and the entry count.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per command (insert, remove, peek, no-op) with a position
//           and, for insert, the word to store.
//   out_* : exactly one transaction per command: the word removed or peeked
//           (zero on insert, no-op or error), a status and the count afterward.
// Timing:
//   A command is taken in the idle state, executed in the next cycle in the
//   shifting storage cells (a whole insert or remove moves the tail at once),
//   and its result is offered from the cycle after that. The sequencer takes
//   no new command until the result of the last one has been taken.
// Reset:
//   rst_n (synchronous) empties the list and drops any result in flight;
//   stored words are not cleared and are never read before written.
// Stall:
//   While out_ready is low the result holds in its register and in_ready
//   stays low, so no further command is taken until the result moves.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store_unit
  import pls_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  wire       out_ready,
  output out_item_t out_data
);

  // command and status between sequencer and datapath
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: handshakes and command decode
  pls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // datapath: storage cells, count, captured command and result register
  pls_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

>>> tb/pls_checker.sv
// ----------------------------------------------------------------------------
// pls_checker: result predictor and comparator for the positional list store
// Watches both channels, keeps its own copy of the list, queues the expected
// result of every accepted command and compares each result against it.
// ----------------------------------------------------------------------------
module pls_checker
  import pls_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  input  wire       in_ready,
  input  in_item_t  in_data,
  input  wire       out_valid,
  input  wire       out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  logic [DATA_WIDTH-1:0] list_words [DEPTH];
  int                    list_len;
  out_item_t             expected_results [$];

  // Apply one command to the shadow list and return the result it must give.
  function automatic out_item_t run_list_command(in_item_t cmd);
    out_item_t res;
    int        p;
    res.read_data = '0;
    res.status    = ST_OK;
    p = int'(cmd.position);
    case (cmd.command)
      CMD_INSERT: begin
        if (p > list_len) begin
          res.status = ST_BAD_POS;
        end else if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = cmd.data_in;
          list_len++;
        end
      end
      CMD_REMOVE, CMD_PEEK: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (p >= list_len) begin
          res.status = ST_BAD_POS;
        end else begin
          res.read_data = list_words[p];
          if (cmd.command == CMD_REMOVE) begin
            for (int i = p; i < list_len - 1; i++) list_words[i] = list_words[i+1];
            list_len--;
          end
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(list_len);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      list_len = 0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(run_list_command(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: data=%h status=%0d count=%0d",
                     out_data.read_data, out_data.status, out_data.count);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_data.read_data !== want.read_data || out_data.status !== want.status ||
              out_data.count !== want.count) begin
            if (fail_count < 10)
              $display("mismatch: exp data=%h status=%0d count=%0d, got data=%h status=%0d count=%0d",
                       want.read_data, want.status, want.count,
                       out_data.read_data, out_data.status, out_data.count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the positional list store
// Drives directed and random insert/remove/peek transactions with random
// idling on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import pls_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int PHASE_LEN    = 100;
  localparam int IDLE_LIMIT   = 2000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int ready_hold = 0;
  int list_level = 0;    // rough fill level, used only to shape stimulus
  bit steady_flow = 1'b0;

  always #4 clk = ~clk;

  positional_list_store_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  pls_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Pick an idle stretch: mostly short, now and then a long one.
  function automatic int idle_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(4, 40);
    return $urandom_range(1, 3);
  endfunction

  // Receiver side: stall out_ready at random, except in steady stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= 1'b0;
    end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
      ready_hold <= idle_gap() - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: end the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Send one command. Hold valid and payload until accepted; drop valid only
  // when an idle gap follows, so a back-to-back command keeps valid high.
  task automatic send_cmd(input cmd_t c, input int p, input logic [DATA_WIDTH-1:0] d,
                          input int gap);
    in_item_t item;
    item.command  = c;
    item.position = p[POS_W-1:0];
    item.data_in  = d;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Track the fill level for biasing the random positions.
    if (c == CMD_INSERT && item.position <= list_level && list_level < DEPTH)
      list_level++;
    else if (c == CMD_REMOVE && list_level > 0 && item.position < list_level)
      list_level--;
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int  r;
    int  mode;
    int  pos;
    int  gap;
    cmd_t c;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list cases, unused code and an insert past the end.
    send_cmd(CMD_PEEK,   0,  32'h1234_5678, 0);
    send_cmd(CMD_REMOVE, 31, 32'h0,         0);
    send_cmd(CMD_NOP,    7,  '1,            1);
    send_cmd(CMD_INSERT, 31, '1,            0);

    // Fill the list to the brim at head, tail and middle positions.
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 3)
        0:       pos = 0;
        1:       pos = list_level;
        default: pos = list_level / 2;
      endcase
      send_cmd(CMD_INSERT, pos, (i == 0) ? '0 : (i == 1) ? '1 : (32'hA5A5_0000 | i),
               i % 2);
    end

    // Full list: valid position gives full, position past the end gives bad position.
    send_cmd(CMD_INSERT, DEPTH,     32'hDEAD_BEEF, 0);
    send_cmd(CMD_INSERT, DEPTH + 1, 32'hDEAD_BEEF, 0);
    send_cmd(CMD_INSERT, 0,         32'hDEAD_BEEF, 2);
    send_cmd(CMD_PEEK,   DEPTH - 1, '0,            0);
    send_cmd(CMD_PEEK,   DEPTH,     '0,            0);
    send_cmd(CMD_REMOVE, 0,         '0,            0);
    send_cmd(CMD_REMOVE, DEPTH - 2, '0,            0);
    send_cmd(CMD_REMOVE, 5,         '0,            1);

    drain_results();

    // Random: phases that fill, drain or mix, most positions well formed.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      mode        = (n / PHASE_LEN) % 4;
      steady_flow = (mode == 3);
      r = $urandom_range(0, 99);
      case (mode)
        0:       c = (r < 60) ? CMD_INSERT : (r < 75) ? CMD_REMOVE :
                     (r < 95) ? CMD_PEEK : CMD_NOP;
        1:       c = (r < 20) ? CMD_INSERT : (r < 70) ? CMD_REMOVE :
                     (r < 95) ? CMD_PEEK : CMD_NOP;
        default: c = (r < 40) ? CMD_INSERT : (r < 65) ? CMD_REMOVE :
                     (r < 95) ? CMD_PEEK : CMD_NOP;
      endcase
      if ($urandom_range(0, 9) < 8) begin
        if (c == CMD_INSERT)
          pos = $urandom_range(0, list_level);
        else
          pos = (list_level == 0) ? 0 : $urandom_range(0, list_level - 1);
      end else begin
        pos = $urandom_range(0, 31);
      end
      gap = steady_flow ? 0 : ($urandom_range(0, 1) ? 0 : idle_gap());
      send_cmd(c, pos, pick_word(), gap);
      // Pause now and then until the block has answered everything.
      if (n % 250 == 249) drain_results();
    end

    // Wait out every outstanding result, then give strays time to show.
    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/pls_pkg.sv
rtl/pls_ctrl.sv
rtl/pls_datapath.sv
rtl/positional_list_store_unit.sv
tb/pls_checker.sv
tb/tb.sv
